// File: hw/rtl/lvbb_pkg.sv
// lvbb_pkg: shared types and constants of the label volume bounding box block
// used by lvbb_ctrl, lvbb_dp, the top level and the checker; depends on nothing

package lvbb_pkg;

   localparam int CFG_W     = 11;
   localparam int MAXLBL_W  = 8;
   localparam int KIND_W    = 2;
   localparam int LABEL_W   = 16;
   localparam int COUNT_W   = 31;
   localparam int COORD_W   = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0]    DIM_RESET       = 11'd1024;
   localparam logic [MAXLBL_W-1:0] MAX_LABEL_RESET = 8'd255;
   localparam logic [COUNT_W-1:0]  COUNT_MAX       = {COUNT_W{1'b1}};

   localparam logic [KIND_W-1:0] KIND_VOXEL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DIM_X     = 2'd0,
      REG_DIM_Y     = 2'd1,
      REG_DIM_Z     = 2'd2,
      REG_MAX_LABEL = 2'd3
   } reg_index_type;

   typedef enum logic {
      ST_SWEEP = 1'b0,
      ST_RUN   = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic s2_adv;
      logic clear_start;
      logic sweep_we;
   } ctrl_cmd_type;

   typedef struct packed {
      logic s2_read;
      logic rsp_valid;
   } dp_status_type;

endpackage

// File: hw/rtl/label_volume_bounding_box.sv
// label_volume_bounding_box: top level, voxel count and 3d bounding box per label
// instantiates lvbb_ctrl and lvbb_dp; uses lvbb_pkg
//
// Voxel words arrive in raster order (x fastest) and are taken one per clock while
// req_stall is low: each voxel reads its label's entry from a single-port-write,
// registered-read memory and writes it back on the next cycle, with a one-entry forward
// covering back-to-back hits on the same label. A read word's result moves from the
// second stage into an output register once no earlier result is stalled there, so
// input keeps flowing while a result waits; a second read waits only while the first
// result is stalled. After reset, and after every clear word, the block sweeps the
// label memory one entry per cycle, with req_stall high throughout; configuration
// writes are taken at any time but belong in idle periods.

module label_volume_bounding_box #(
   parameter int NUM_LABELS = 256,
   parameter int MAX_DIM    = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lvbb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lvbb_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lvbb_pkg::KIND_W-1:0]         req_kind,
   input  logic [lvbb_pkg::LABEL_W-1:0]        req_label,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lvbb_pkg::COUNT_W-1:0]        rsp_voxel_count,
   output logic [lvbb_pkg::COORD_W-1:0]        rsp_min_x,
   output logic [lvbb_pkg::COORD_W-1:0]        rsp_min_y,
   output logic [lvbb_pkg::COORD_W-1:0]        rsp_min_z,
   output logic [lvbb_pkg::COORD_W-1:0]        rsp_max_x,
   output logic [lvbb_pkg::COORD_W-1:0]        rsp_max_y,
   output logic [lvbb_pkg::COORD_W-1:0]        rsp_max_z
);

   localparam int LW = $clog2(NUM_LABELS);

   lvbb_pkg::ctrl_cmd_type  cmd;
   lvbb_pkg::dp_status_type status;
   logic [LW-1:0]           sweep_addr;

   lvbb_ctrl #(
      .NUM_LABELS (NUM_LABELS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_kind   (req_kind),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .sweep_addr (sweep_addr)
   );

   lvbb_dp #(
      .NUM_LABELS (NUM_LABELS),
      .MAX_DIM    (MAX_DIM)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sweep_addr      (sweep_addr),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_kind        (req_kind),
      .req_label       (req_label),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_voxel_count (rsp_voxel_count),
      .rsp_min_x       (rsp_min_x),
      .rsp_min_y       (rsp_min_y),
      .rsp_min_z       (rsp_min_z),
      .rsp_max_x       (rsp_max_x),
      .rsp_max_y       (rsp_max_y),
      .rsp_max_z       (rsp_max_z)
   );

endmodule

// File: hw/rtl/lvbb_ctrl.sv
// lvbb_ctrl: controller of the label volume bounding box block
// handshake decisions, clearing sweep state machine; uses lvbb_pkg

module lvbb_ctrl #(
   parameter int NUM_LABELS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [lvbb_pkg::KIND_W-1:0]         req_kind,
   input  logic                                rsp_stall,
   input  lvbb_pkg::dp_status_type             status,
   output logic                                req_stall,
   output lvbb_pkg::ctrl_cmd_type              cmd,
   output logic [$clog2(NUM_LABELS)-1:0]       sweep_addr
);

   localparam int LW = $clog2(NUM_LABELS);
   localparam logic [LW-1:0] LAST_ADDR = LW'(NUM_LABELS - 1);

   lvbb_pkg::ctrl_state_type state_ff, state_in;
   logic [LW-1:0]            sweep_ff, sweep_in;
   logic                     s2_block;

   assign s2_block   = status.s2_read && status.rsp_valid && rsp_stall;
   assign sweep_addr = sweep_ff;

   // outputs
   always_comb begin
      req_stall       = (state_ff != lvbb_pkg::ST_RUN) || s2_block;
      cmd.accept      = req_valid && !req_stall;
      cmd.s2_adv      = !s2_block;
      cmd.clear_start = cmd.accept && (req_kind == lvbb_pkg::KIND_CLEAR);
      cmd.sweep_we    = (state_ff == lvbb_pkg::ST_SWEEP);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      unique case (state_ff)
         lvbb_pkg::ST_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               state_in = lvbb_pkg::ST_RUN;
               sweep_in = '0;
            end
         end
         lvbb_pkg::ST_RUN: begin
            if (cmd.clear_start) begin
               state_in = lvbb_pkg::ST_SWEEP;
               sweep_in = '0;
            end
         end
         default: begin
            state_in = lvbb_pkg::ST_SWEEP;
            sweep_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lvbb_pkg::ST_SWEEP;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

endmodule

// File: hw/rtl/lvbb_dp.sv
// lvbb_dp: datapath of the label volume bounding box block
// config registers, scan position, label memory with forwarding, result word; uses lvbb_pkg

module lvbb_dp #(
   parameter int NUM_LABELS = 256,
   parameter int MAX_DIM    = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lvbb_pkg::ctrl_cmd_type                cmd,
   input  logic [$clog2(NUM_LABELS)-1:0]         sweep_addr,
   output lvbb_pkg::dp_status_type               status,
   input  logic                                  csr_we,
   input  logic [lvbb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lvbb_pkg::CFG_W-1:0]            csr_wdata,
   input  logic [lvbb_pkg::KIND_W-1:0]           req_kind,
   input  logic [lvbb_pkg::LABEL_W-1:0]          req_label,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [lvbb_pkg::COUNT_W-1:0]          rsp_voxel_count,
   output logic [lvbb_pkg::COORD_W-1:0]          rsp_min_x,
   output logic [lvbb_pkg::COORD_W-1:0]          rsp_min_y,
   output logic [lvbb_pkg::COORD_W-1:0]          rsp_min_z,
   output logic [lvbb_pkg::COORD_W-1:0]          rsp_max_x,
   output logic [lvbb_pkg::COORD_W-1:0]          rsp_max_y,
   output logic [lvbb_pkg::COORD_W-1:0]          rsp_max_z
);

   localparam int LW  = $clog2(NUM_LABELS);
   localparam int CW  = $clog2(MAX_DIM);
   localparam int CNW = lvbb_pkg::COUNT_W;
   localparam int EW  = CNW + 6 * CW;
   localparam int RST_DIM = (1024 > MAX_DIM) ? MAX_DIM : 1024;
   localparam logic [CW-1:0] RST_MIN = CW'(RST_DIM - 1);

   function automatic logic [CW-1:0] eff_m1(input logic [lvbb_pkg::CFG_W-1:0] d);
      logic [CW-1:0] r;
      if (d == '0) begin
         r = '0;
      end else if (32'(d) > MAX_DIM) begin
         r = CW'(MAX_DIM - 1);
      end else begin
         r = CW'(d - 1'b1);
      end
      return r;
   endfunction

   // configuration
   logic [lvbb_pkg::CFG_W-1:0]    dim_x_ff, dim_y_ff, dim_z_ff;
   logic [lvbb_pkg::MAXLBL_W-1:0] max_label_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff     <= lvbb_pkg::DIM_RESET;
         dim_y_ff     <= lvbb_pkg::DIM_RESET;
         dim_z_ff     <= lvbb_pkg::DIM_RESET;
         max_label_ff <= lvbb_pkg::MAX_LABEL_RESET;
      end else if (csr_we) begin
         unique case (lvbb_pkg::reg_index_type'(csr_index))
            lvbb_pkg::REG_DIM_X:     dim_x_ff     <= csr_wdata;
            lvbb_pkg::REG_DIM_Y:     dim_y_ff     <= csr_wdata;
            lvbb_pkg::REG_DIM_Z:     dim_z_ff     <= csr_wdata;
            lvbb_pkg::REG_MAX_LABEL: max_label_ff <= csr_wdata[lvbb_pkg::MAXLBL_W-1:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0] lim_x, lim_y, lim_z;
   assign lim_x = eff_m1(dim_x_ff);
   assign lim_y = eff_m1(dim_y_ff);
   assign lim_z = eff_m1(dim_z_ff);

   // scan position
   logic [CW-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [CW-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic          wrap_x, wrap_y, wrap_z, is_voxel;

   assign is_voxel = cmd.accept && (req_kind == lvbb_pkg::KIND_VOXEL);
   assign wrap_x   = pos_x_ff >= lim_x;
   assign wrap_y   = pos_y_ff >= lim_y;
   assign wrap_z   = pos_z_ff >= lim_z;

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (cmd.clear_start) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
      end else if (is_voxel) begin
         pos_x_in = wrap_x ? '0 : pos_x_ff + 1'b1;
         if (wrap_x) begin
            pos_y_in = wrap_y ? '0 : pos_y_ff + 1'b1;
            if (wrap_y) begin
               pos_z_in = wrap_z ? '0 : pos_z_ff + 1'b1;
            end
         end
      end
   end

   // minimums for empty entries, taken at clear
   logic [CW-1:0] clr_x_ff, clr_y_ff, clr_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         clr_x_ff <= RST_MIN;
         clr_y_ff <= RST_MIN;
         clr_z_ff <= RST_MIN;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         if (cmd.clear_start) begin
            clr_x_ff <= lim_x;
            clr_y_ff <= lim_y;
            clr_z_ff <= lim_z;
         end
      end
   end

   // second stage: item whose memory word is being read
   logic                        s2_valid_ff;
   logic [lvbb_pkg::KIND_W-1:0] s2_kind_ff;
   logic [LW-1:0]               s2_addr_ff;
   logic                        s2_counted_ff, s2_oob_ff;
   logic [CW-1:0]               s2_cx_ff, s2_cy_ff, s2_cz_ff;
   logic                        in_store, counted;

   assign in_store = 32'(req_label) < NUM_LABELS;
   assign counted  = (req_label != '0) && (32'(req_label) <= 32'(max_label_ff)) && in_store;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (cmd.accept) begin
         s2_valid_ff <= 1'b1;
      end else if (cmd.s2_adv) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         s2_kind_ff    <= req_kind;
         s2_addr_ff    <= req_label[LW-1:0];
         s2_counted_ff <= counted;
         s2_oob_ff     <= !in_store;
         s2_cx_ff      <= pos_x_ff;
         s2_cy_ff      <= pos_y_ff;
         s2_cz_ff      <= pos_z_ff;
      end
   end

   // label memory
   logic [EW-1:0] mem [NUM_LABELS];
   logic [EW-1:0] rd_data_ff;
   logic          mem_we;
   logic [LW-1:0] mem_wa;
   logic [EW-1:0] mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.accept) begin
         rd_data_ff <= mem[req_label[LW-1:0]];
      end
   end

   // forwarding of the write made at the edge that loaded the second stage
   logic          fwd_valid_ff;
   logic [LW-1:0] fwd_addr_ff;
   logic [EW-1:0] fwd_data_ff;

   logic [EW-1:0]  cur, upd, empty_word;
   logic [CNW-1:0] cur_cnt, upd_cnt;
   logic [CW-1:0]  cur_lx, cur_ly, cur_lz, cur_hx, cur_hy, cur_hz;
   logic [CW-1:0]  upd_lx, upd_ly, upd_lz, upd_hx, upd_hy, upd_hz;
   logic           vox_we, s2_is_read;

   always_comb begin
      cur = (fwd_valid_ff && (fwd_addr_ff == s2_addr_ff)) ? fwd_data_ff : rd_data_ff;
      cur_cnt = cur[CNW-1:0];
      cur_lx  = cur[CNW + 0*CW +: CW];
      cur_ly  = cur[CNW + 1*CW +: CW];
      cur_lz  = cur[CNW + 2*CW +: CW];
      cur_hx  = cur[CNW + 3*CW +: CW];
      cur_hy  = cur[CNW + 4*CW +: CW];
      cur_hz  = cur[CNW + 5*CW +: CW];
      upd_cnt = (cur_cnt == lvbb_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
      upd_lx  = (s2_cx_ff < cur_lx) ? s2_cx_ff : cur_lx;
      upd_ly  = (s2_cy_ff < cur_ly) ? s2_cy_ff : cur_ly;
      upd_lz  = (s2_cz_ff < cur_lz) ? s2_cz_ff : cur_lz;
      upd_hx  = (s2_cx_ff > cur_hx) ? s2_cx_ff : cur_hx;
      upd_hy  = (s2_cy_ff > cur_hy) ? s2_cy_ff : cur_hy;
      upd_hz  = (s2_cz_ff > cur_hz) ? s2_cz_ff : cur_hz;
      upd = {upd_hz, upd_hy, upd_hx, upd_lz, upd_ly, upd_lx, upd_cnt};
      empty_word = {{(3*CW){1'b0}}, clr_z_ff, clr_y_ff, clr_x_ff, {CNW{1'b0}}};
      vox_we = s2_valid_ff && (s2_kind_ff == lvbb_pkg::KIND_VOXEL) && s2_counted_ff
               && cmd.s2_adv;
      s2_is_read = s2_valid_ff && (s2_kind_ff == lvbb_pkg::KIND_READ);
      mem_we = cmd.sweep_we || vox_we;
      mem_wa = cmd.sweep_we ? sweep_addr : s2_addr_ff;
      mem_wd = cmd.sweep_we ? empty_word : upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (cmd.accept) begin
         fwd_valid_ff <= vox_we;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         fwd_addr_ff <= s2_addr_ff;
         fwd_data_ff <= upd;
      end
   end

   // result word
   logic rsp_valid_ff;
   logic rsp_load;

   assign rsp_load         = s2_is_read && cmd.s2_adv;
   assign status.s2_read   = s2_is_read;
   assign status.rsp_valid = rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (s2_oob_ff) begin
            rsp_voxel_count <= '0;
            rsp_min_x       <= lvbb_pkg::COORD_W'(lim_x);
            rsp_min_y       <= lvbb_pkg::COORD_W'(lim_y);
            rsp_min_z       <= lvbb_pkg::COORD_W'(lim_z);
            rsp_max_x       <= '0;
            rsp_max_y       <= '0;
            rsp_max_z       <= '0;
         end else begin
            rsp_voxel_count <= cur_cnt;
            rsp_min_x       <= lvbb_pkg::COORD_W'(cur_lx);
            rsp_min_y       <= lvbb_pkg::COORD_W'(cur_ly);
            rsp_min_z       <= lvbb_pkg::COORD_W'(cur_lz);
            rsp_max_x       <= lvbb_pkg::COORD_W'(cur_hx);
            rsp_max_y       <= lvbb_pkg::COORD_W'(cur_hy);
            rsp_max_z       <= lvbb_pkg::COORD_W'(cur_hz);
         end
      end
   end

endmodule

// File: hw/rtl/lvbb_checker.sv
// lvbb_checker: port-level assertions for label_volume_bounding_box
// bound to the top level below; uses lvbb_pkg

module lvbb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [lvbb_pkg::KIND_W-1:0]         req_kind,
   input logic                                rsp_valid,
   input logic                                rsp_stall
);

   // a pending result is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // memory sweep follows reset
   a_init_sweep: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("input taken during initial sweep");

   // a clear word starts a sweep
   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == lvbb_pkg::KIND_CLEAR) |=> req_stall)
      else $error("input taken right after clear");

   // a new result only comes from an accepted read word
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall
                                 && (req_kind == lvbb_pkg::KIND_READ), 2))
      else $error("result word without a read");

endmodule

bind label_volume_bounding_box lvbb_checker u_lvbb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_kind  (req_kind),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

// File: sim/label_stats_checker.sv
// label_stats_checker: tracks csr writes and accepted request words, predicts each label's
// voxel count and bounding box, and compares every accepted response word in order
// uses lvbb_pkg; instantiated by tb beside label_volume_bounding_box

module label_stats_checker
   import lvbb_pkg::*;
#(
   parameter int NUM_LABELS = 256,
   parameter int MAX_DIM    = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [LABEL_W-1:0]   req_label,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [COUNT_W-1:0]   rsp_voxel_count,
   input  logic [COORD_W-1:0]   rsp_min_x,
   input  logic [COORD_W-1:0]   rsp_min_y,
   input  logic [COORD_W-1:0]   rsp_min_z,
   input  logic [COORD_W-1:0]   rsp_max_x,
   input  logic [COORD_W-1:0]   rsp_max_y,
   input  logic [COORD_W-1:0]   rsp_max_z,
   output int                   failures,
   output int                   outstanding
);

   typedef struct packed {
      logic [COUNT_W-1:0] voxels;
      logic [COORD_W-1:0] lo_x;
      logic [COORD_W-1:0] lo_y;
      logic [COORD_W-1:0] lo_z;
      logic [COORD_W-1:0] hi_x;
      logic [COORD_W-1:0] hi_y;
      logic [COORD_W-1:0] hi_z;
   } label_stats_type;

   label_stats_type     stats [NUM_LABELS];
   label_stats_type     expected_stats [$];
   logic [CFG_W-1:0]    dim_x;
   logic [CFG_W-1:0]    dim_y;
   logic [CFG_W-1:0]    dim_z;
   logic [MAXLBL_W-1:0] label_limit;
   int                  pos_x;
   int                  pos_y;
   int                  pos_z;

   initial failures = 0;

   function automatic int span(logic [CFG_W-1:0] d);
      if (d == '0) return 1;
      if (int'(d) > MAX_DIM) return MAX_DIM;
      return int'(d);
   endfunction

   function automatic label_stats_type empty_stats();
      label_stats_type e;
      e = '0;
      e.lo_x = COORD_W'(span(dim_x) - 1);
      e.lo_y = COORD_W'(span(dim_y) - 1);
      e.lo_z = COORD_W'(span(dim_z) - 1);
      return e;
   endfunction

   task automatic wipe();
      for (int n = 0; n < NUM_LABELS; n++) stats[n] = empty_stats();
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
   endtask

   task automatic add_voxel(logic [LABEL_W-1:0] lab);
      int              lim;
      label_stats_type s;
      lim = (int'(label_limit) > NUM_LABELS - 1) ? NUM_LABELS - 1 : int'(label_limit);
      if (lab != '0 && int'(lab) <= lim) begin
         s = stats[lab];
         if (s.voxels != COUNT_MAX) s.voxels = s.voxels + 1'b1;
         if (pos_x < int'(s.lo_x)) s.lo_x = COORD_W'(pos_x);
         if (pos_y < int'(s.lo_y)) s.lo_y = COORD_W'(pos_y);
         if (pos_z < int'(s.lo_z)) s.lo_z = COORD_W'(pos_z);
         if (pos_x > int'(s.hi_x)) s.hi_x = COORD_W'(pos_x);
         if (pos_y > int'(s.hi_y)) s.hi_y = COORD_W'(pos_y);
         if (pos_z > int'(s.hi_z)) s.hi_z = COORD_W'(pos_z);
         stats[lab] = s;
      end
      // raster advance, a counter past a lowered dimension wraps and carries
      if (pos_x >= span(dim_x) - 1) begin
         pos_x = 0;
         if (pos_y >= span(dim_y) - 1) begin
            pos_y = 0;
            if (pos_z >= span(dim_z) - 1) pos_z = 0;
            else pos_z++;
         end else begin
            pos_y++;
         end
      end else begin
         pos_x++;
      end
   endtask

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      label_stats_type want;
      if (reset) begin
         dim_x       = DIM_RESET;
         dim_y       = DIM_RESET;
         dim_z       = DIM_RESET;
         label_limit = MAX_LABEL_RESET;
         wipe();
         expected_stats.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_DIM_X:     dim_x = csr_wdata;
               REG_DIM_Y:     dim_y = csr_wdata;
               REG_DIM_Z:     dim_z = csr_wdata;
               REG_MAX_LABEL: label_limit = csr_wdata[MAXLBL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_kind)
               KIND_VOXEL: add_voxel(req_label);
               KIND_READ: begin
                  if (int'(req_label) < NUM_LABELS) expected_stats.push_back(stats[req_label]);
                  else expected_stats.push_back(empty_stats());
               end
               KIND_CLEAR: wipe();
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               $error("response word with no read pending");
               failures++;
            end else begin
               want = expected_stats.pop_front();
               check_field("rsp_voxel_count", want.voxels, rsp_voxel_count);
               check_field("rsp_min_x", want.lo_x, rsp_min_x);
               check_field("rsp_min_y", want.lo_y, rsp_min_y);
               check_field("rsp_min_z", want.lo_z, rsp_min_z);
               check_field("rsp_max_x", want.hi_x, rsp_max_x);
               check_field("rsp_max_y", want.hi_y, rsp_max_y);
               check_field("rsp_max_z", want.hi_z, rsp_max_z);
            end
         end
      end
      outstanding <= expected_stats.size();
   end

endmodule

// File: sim/tb.sv
// tb: drives label_volume_bounding_box with a directed scan and random phases over several
// dimension and label-limit settings, with random idles and response stalls
// depends on lvbb_pkg, label_volume_bounding_box and label_stats_checker

module tb;
   import lvbb_pkg::*;

   localparam int NUM_LABELS  = 256;
   localparam int MAX_DIM     = 1024;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_WORDS = 133;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_DIM_X;
   logic [CFG_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [KIND_W-1:0]    req_kind  = KIND_VOXEL;
   logic [LABEL_W-1:0]   req_label = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COUNT_W-1:0]   rsp_voxel_count;
   logic [COORD_W-1:0]   rsp_min_x;
   logic [COORD_W-1:0]   rsp_min_y;
   logic [COORD_W-1:0]   rsp_min_z;
   logic [COORD_W-1:0]   rsp_max_x;
   logic [COORD_W-1:0]   rsp_max_y;
   logic [COORD_W-1:0]   rsp_max_z;
   int                   failures;
   int                   outstanding;
   int                   quiet_cycles = 0;
   logic                 calm = 1'b0;

   label_volume_bounding_box #(.NUM_LABELS(NUM_LABELS), .MAX_DIM(MAX_DIM)) dut (.*);

   label_stats_checker #(.NUM_LABELS(NUM_LABELS), .MAX_DIM(MAX_DIM)) checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 33);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [LABEL_W-1:0] label);
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_label <= label;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!calm && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // no reads pending, then room for the clear sweep and the write-back to finish
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (NUM_LABELS + 8) @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] dx, dy, dz, ml);
      csr_we    <= 1'b1;
      csr_index <= REG_DIM_X;
      csr_wdata <= dx;
      @(posedge clock);
      csr_index <= REG_DIM_Y;
      csr_wdata <= dy;
      @(posedge clock);
      csr_index <= REG_DIM_Z;
      csr_wdata <= dz;
      @(posedge clock);
      csr_index <= REG_MAX_LABEL;
      csr_wdata <= ml;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_word(input logic [MAXLBL_W-1:0] ml);
      int                 pick;
      logic [KIND_W-1:0]  kind;
      logic [LABEL_W-1:0] label;
      pick = $urandom_range(99);
      if (pick < 68) kind = KIND_VOXEL;
      else if (pick < 90) kind = KIND_READ;
      else if (pick < 93) kind = KIND_CLEAR;
      else kind = KIND_UNUSED;
      pick = $urandom_range(9);
      if (pick < 7) label = LABEL_W'($urandom_range(0, int'(ml) + 1));
      else if (pick < 9) label = LABEL_W'($urandom_range(0, NUM_LABELS - 1));
      else label = LABEL_W'($urandom_range(0, 65535));
      send_word(kind, label);
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] dx, dy, dz, ml, input int words);
      quiesce();
      configure(dx, dy, dz, ml);
      repeat (words) random_word(ml[MAXLBL_W-1:0]);
   endtask

   initial begin
      logic [LABEL_W-1:0] scan_labels [13];
      scan_labels = '{16'd1, 16'd5, 16'd6, 16'd0, 16'd65535, 16'd2, 16'd1,
                      16'd5, 16'd3, 16'd1, 16'd4, 16'd2, 16'd1};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      quiesce();

      configure(11'd3, 11'd2, 11'd2, 11'd5);
      send_word(KIND_READ, 16'd0);
      send_word(KIND_READ, 16'd300);
      foreach (scan_labels[i]) send_word(KIND_VOXEL, scan_labels[i]);
      send_word(KIND_READ, 16'd1);
      send_word(KIND_READ, 16'd2);
      send_word(KIND_READ, 16'd5);
      send_word(KIND_READ, 16'd6);
      send_word(KIND_READ, 16'd65535);
      send_word(KIND_UNUSED, 16'hffff);
      send_word(KIND_CLEAR, 16'd1);
      send_word(KIND_READ, 16'd1);
      send_word(KIND_READ, 16'd255);

      run_phase(11'd0, 11'd0, 11'd0, 11'd0, PHASE_WORDS);
      run_phase(11'd2047, 11'd1024, 11'd2047, 11'd255, PHASE_WORDS);
      calm <= 1'b1;
      run_phase(11'd4, 11'd3, 11'd2, 11'h707, PHASE_WORDS);
      calm <= 1'b0;
      run_phase(11'd1, 11'd5, 11'd1, 11'd3, PHASE_WORDS);
      run_phase(11'd6, 11'd4, 11'd3, 11'h6c8, PHASE_WORDS);
      run_phase(11'd2, 11'd2, 11'd2, 11'd1, PHASE_WORDS);
      run_phase(11'd1025, 11'd1, 11'd3, 11'd12, PHASE_WORDS);
      repeat (3) begin
         run_phase(CFG_W'($urandom_range(1, 9)), CFG_W'($urandom_range(1, 9)),
                   CFG_W'($urandom_range(1, 9)),
                   {3'($urandom), 8'($urandom_range(1, 12))}, PHASE_WORDS);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (failures == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
